>>> rtl/kswb_pkg.sv
// kswb_pkg: types and constants shared by the k-server work-balance dispatcher.
// No dependencies.
package kswb_pkg;

   localparam int COORD_BITS = 12;
   localparam int IDX_BITS   = 4;
   localparam int CSR_BITS   = 5;
   localparam int ROOT_BITS  = COORD_BITS + 1;
   localparam int RAD_BITS   = 2 * ROOT_BITS;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int SUM_BITS   = 32;

   localparam logic [1:0] OP_PLACE   = 2'd0;
   localparam logic [1:0] OP_REQUEST = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   typedef struct packed {
      logic [1:0]            opcode;
      logic [IDX_BITS-1:0]   server_index;
      logic [COORD_BITS-1:0] point_x;
      logic [COORD_BITS-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]  chosen_server;
      logic [ROOT_BITS-1:0] step_cost;
      logic [SUM_BITS-1:0]  chosen_travel;
      logic [SUM_BITS-1:0]  total_cost;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } home_word_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [SUM_BITS-1:0]   travel;
   } run_word_type;

   typedef struct packed {
      logic place;
      logic move;
      logic restart;
   } mem_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIFF,
      ST_SQUARE,
      ST_LOAD,
      ST_ROOT
   } state_type;

endpackage

>>> rtl/kswb_mem.sv
// kswb_mem: home and running-state memories with per-entry valid bits.
// Entries without a running word read as home / zero travel, or all zero if never placed. Uses kswb_pkg.
module kswb_mem import kswb_pkg::*; #(
   parameter int MAX_SERVERS = 16,
   parameter int AW          = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  mem_wr_type   wr,
   input  logic [AW-1:0] wr_addr,
   input  run_word_type wr_run,
   input  logic         rd_en,
   input  logic [AW-1:0] rd_addr,
   output run_word_type rd_word
);

   home_word_type home_mem [MAX_SERVERS];
   run_word_type  run_mem  [MAX_SERVERS];

   logic [MAX_SERVERS-1:0] home_vld_ff, home_vld_in;
   logic [MAX_SERVERS-1:0] run_vld_ff, run_vld_in;
   home_word_type          home_q_ff;
   run_word_type           run_q_ff;
   logic                   home_hit_ff, run_hit_ff;

   always_ff @(posedge clock) begin
      if (wr.place) begin
         home_mem[wr_addr] <= '{x: wr_run.x, y: wr_run.y};
      end
      if (wr.move) begin
         run_mem[wr_addr] <= wr_run;
      end
      if (rd_en) begin
         home_q_ff   <= home_mem[rd_addr];
         run_q_ff    <= run_mem[rd_addr];
         home_hit_ff <= home_vld_ff[rd_addr];
         run_hit_ff  <= run_vld_ff[rd_addr];
      end
   end

   always_comb begin
      home_vld_in = home_vld_ff;
      run_vld_in  = run_vld_ff;
      if (wr.restart) begin
         run_vld_in = '0;
      end
      if (wr.place) begin
         home_vld_in[wr_addr] = 1'b1;
         run_vld_in[wr_addr]  = 1'b0;
      end
      if (wr.move) begin
         run_vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         home_vld_ff <= '0;
         run_vld_ff  <= '0;
      end else begin
         home_vld_ff <= home_vld_in;
         run_vld_ff  <= run_vld_in;
      end
   end

   always_comb begin
      if (run_hit_ff) begin
         rd_word = run_q_ff;
      end else if (home_hit_ff) begin
         rd_word = '{x: home_q_ff.x, y: home_q_ff.y, travel: '0};
      end else begin
         rd_word = '0;
      end
   end

endmodule

>>> rtl/kswb_isqrt.sv
// kswb_isqrt: iterative integer square root, one result bit per cycle.
// Uses kswb_pkg for operand and root widths.
module kswb_isqrt import kswb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [RAD_BITS-1:0]  operand,
   output logic                 done,
   output logic [ROOT_BITS-1:0] root
);

   localparam int NW = $clog2(ROOT_BITS + 1);
   localparam logic [RAD_BITS-1:0] BIT_INIT = {2'b01, {(RAD_BITS-2){1'b0}}};

   logic [RAD_BITS-1:0] rem_ff, rem_in;
   logic [RAD_BITS-1:0] res_ff, res_in;
   logic [RAD_BITS-1:0] bit_ff, bit_in;
   logic [NW-1:0]       cnt_ff, cnt_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [RAD_BITS:0]   trial;

   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = operand;
         res_in = '0;
         bit_in = BIT_INIT;
         cnt_in = NW'(ROOT_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = rem_ff - trial[RAD_BITS-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - NW'(1);
         if (cnt_ff == NW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_BITS-1:0];

endmodule

>>> rtl/k_server_work_balance_dispatch_core.sv
// k-server work-balance dispatcher. Place, restart and unknown words: strobe in the cycle after
// start, next word taken in the next cycle. Request: strobe after the travel scan of the n servers
// in use (clamped to 1..MAX_SERVERS), the DIFF, SQUARE and LOAD states and the root unit; next
// word taken in the strobe cycle. The travel scan reads one entry a cycle.
// Results are shown for one cycle; the receiver cannot stall. Synchronous reset clears valid
// bits, total cost and sets servers in use to 1. Depends on kswb_pkg, kswb_mem, kswb_isqrt.
module k_server_work_balance_dispatch_core import kswb_pkg::*; #(
   parameter int MAX_SERVERS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_item,
   output logic                rsp_valid,
   output rsp_type             rsp_item,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_BITS-1:0] csr_data
);

   localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CW = $clog2(MAX_SERVERS + 1);

   state_type state_ff, state_in;

   logic [CSR_BITS-1:0]   csr_ff;
   logic [SUM_BITS-1:0]   cost_ff, cost_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   req_type               req_ff, req_in;
   logic [CW-1:0]         iss_ff, iss_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pidx_ff, pidx_in;
   logic [AW-1:0]         best_idx_ff, best_idx_in;
   run_word_type          best_ff, best_in;
   logic [COORD_BITS-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ_BITS-1:0]    dxsq_ff, dxsq_in, dysq_ff, dysq_in;

   logic                 accept;
   logic [CW-1:0]        lim;
   mem_wr_type           wr;
   logic [AW-1:0]        wr_addr;
   run_word_type         wr_run;
   logic                 rd_en;
   run_word_type         rd_word;
   logic                 sq_start;
   logic [RAD_BITS-1:0]  sq_operand;
   logic                 sq_done;
   logic [ROOT_BITS-1:0] root;
   logic [SUM_BITS:0]    trav_sum, cost_sum;
   logic [SUM_BITS-1:0]  new_trav, new_cost;
   logic                 place_ok;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign place_ok  = (32'(req_item.server_index) < MAX_SERVERS);

   always_comb begin
      priority if (csr_ff == '0) begin
         lim = CW'(1);
      end else if (32'(csr_ff) > MAX_SERVERS) begin
         lim = CW'(MAX_SERVERS);
      end else begin
         lim = CW'(csr_ff);
      end
   end

   assign trav_sum   = {1'b0, best_ff.travel} + (SUM_BITS+1)'(root);
   assign cost_sum   = {1'b0, cost_ff} + (SUM_BITS+1)'(root);
   assign new_trav   = trav_sum[SUM_BITS] ? '1 : trav_sum[SUM_BITS-1:0];
   assign new_cost   = cost_sum[SUM_BITS] ? '1 : cost_sum[SUM_BITS-1:0];
   assign sq_operand = RAD_BITS'(dxsq_ff) + RAD_BITS'(dysq_ff);

   kswb_mem #(
      .MAX_SERVERS(MAX_SERVERS),
      .AW         (AW)
   ) u_mem (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .wr_addr(wr_addr),
      .wr_run (wr_run),
      .rd_en  (rd_en),
      .rd_addr(iss_ff[AW-1:0]),
      .rd_word(rd_word)
   );

   kswb_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (sq_start),
      .operand(sq_operand),
      .done   (sq_done),
      .root   (root)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_item.opcode == OP_REQUEST) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!rd_en && !pend_ff) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_ROOT;
         ST_ROOT: begin
            if (sq_done) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // memory and root unit controls
   always_comb begin
      wr       = '0;
      wr_addr  = '0;
      wr_run   = '0;
      rd_en    = 1'b0;
      sq_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_item.opcode)
                  OP_PLACE: begin
                     wr.place = place_ok;
                     wr_addr  = AW'(req_item.server_index);
                     wr_run   = '{x: req_item.point_x, y: req_item.point_y, travel: '0};
                  end
                  OP_RESTART: wr.restart = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_SCAN:  rd_en    = (iss_ff < lim);
         ST_LOAD:  sq_start = 1'b1;
         ST_ROOT: begin
            if (sq_done) begin
               wr.move = 1'b1;
               wr_addr = best_idx_ff;
               wr_run  = '{x: req_ff.point_x, y: req_ff.point_y, travel: new_trav};
            end
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      req_in       = req_ff;
      cost_in      = cost_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      iss_in       = iss_ff;
      pend_in      = 1'b0;
      pidx_in      = iss_ff[AW-1:0];
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dxsq_in      = dxsq_ff;
      dysq_in      = dysq_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_item;
               iss_in = '0;
               rsp_in = '{chosen_server: '0, step_cost: '0, chosen_travel: '0,
                          total_cost: cost_ff};
               unique case (req_item.opcode)
                  OP_PLACE: begin
                     rsp_in.chosen_server = req_item.server_index;
                     rsp_valid_in         = 1'b1;
                  end
                  OP_REQUEST: ;
                  OP_RESTART: begin
                     cost_in           = '0;
                     rsp_in.total_cost = '0;
                     rsp_valid_in      = 1'b1;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               iss_in  = iss_ff + CW'(1);
               pend_in = 1'b1;
            end
            if (pend_ff && (pidx_ff == '0 || rd_word.travel < best_ff.travel)) begin
               best_in     = rd_word;
               best_idx_in = pidx_ff;
            end
         end
         ST_DIFF: begin
            dx_in = (best_ff.x > req_ff.point_x) ? best_ff.x - req_ff.point_x
                                                 : req_ff.point_x - best_ff.x;
            dy_in = (best_ff.y > req_ff.point_y) ? best_ff.y - req_ff.point_y
                                                 : req_ff.point_y - best_ff.y;
         end
         ST_SQUARE: begin
            dxsq_in = SQ_BITS'(dx_ff) * SQ_BITS'(dx_ff);
            dysq_in = SQ_BITS'(dy_ff) * SQ_BITS'(dy_ff);
         end
         ST_LOAD: ;
         ST_ROOT: begin
            if (sq_done) begin
               cost_in      = new_cost;
               rsp_in       = '{chosen_server: IDX_BITS'(best_idx_ff), step_cost: root,
                                chosen_travel: new_trav, total_cost: new_cost};
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_ff       <= CSR_BITS'(1);
         cost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         iss_ff       <= '0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cost_ff      <= cost_in;
         rsp_valid_ff <= rsp_valid_in;
         iss_ff       <= iss_in;
         pend_ff      <= pend_in;
         if (csr_valid && csr_ready) begin
            csr_ff <= csr_data;
         end
      end
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      pidx_ff     <= pidx_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dxsq_ff     <= dxsq_in;
      dysq_ff     <= dysq_in;
   end

endmodule

>>> tb/sv/tb_k_server_work_balance_dispatch_core.sv
`timescale 1ns / 1ps
// Testbench for k_server_work_balance_dispatch_core: directed and random place, request and
// restart words over several server counts, each result checked against a local model.
// Depends on kswb_pkg and the dispatcher RTL.
module tb_k_server_work_balance_dispatch_core;
   import kswb_pkg::*;

   localparam int NUM_SERVERS = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 48;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

   class dispatch_tracker;
      logic [COORD_BITS-1:0] home_x [NUM_SERVERS];
      logic [COORD_BITS-1:0] home_y [NUM_SERVERS];
      logic [COORD_BITS-1:0] pos_x [NUM_SERVERS];
      logic [COORD_BITS-1:0] pos_y [NUM_SERVERS];
      logic [SUM_BITS-1:0]   travel [NUM_SERVERS];
      logic [SUM_BITS-1:0]   cost_total;
      logic [CSR_BITS-1:0]   servers_cfg;
      rsp_type               pending_results[$];
      int                    mismatches;
      int                    seen;

      function new();
         for (int i = 0; i < NUM_SERVERS; i++) begin
            home_x[i] = '0;
            home_y[i] = '0;
            pos_x[i]  = '0;
            pos_y[i]  = '0;
            travel[i] = '0;
         end
         cost_total  = '0;
         servers_cfg = 5'd1;
         mismatches  = 0;
         seen        = 0;
      endfunction

      function automatic logic [SUM_BITS-1:0] sum_clip(logic [SUM_BITS-1:0] a,
                                                       logic [SUM_BITS-1:0] b);
         logic [SUM_BITS:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
      endfunction

      function automatic logic [ROOT_BITS-1:0] hop_length(logic [COORD_BITS-1:0] ax,
                                                          logic [COORD_BITS-1:0] ay,
                                                          logic [COORD_BITS-1:0] bx,
                                                          logic [COORD_BITS-1:0] by);
         int unsigned dx;
         int unsigned dy;
         int unsigned sq;
         int unsigned root;
         int unsigned trial;
         dx   = (ax > bx) ? ax - bx : bx - ax;
         dy   = (ay > by) ? ay - by : by - ay;
         sq   = dx * dx + dy * dy;
         root = 0;
         for (int b = ROOT_BITS - 1; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= sq) root = trial;
         end
         return root[ROOT_BITS-1:0];
      endfunction

      function void note_word(req_type w);
         rsp_type             r;
         int                  n;
         int                  pick;
         logic [ROOT_BITS-1:0] hop;
         r    = '0;
         pick = 0;
         case (w.opcode)
            OP_PLACE: begin
               home_x[w.server_index] = w.point_x;
               home_y[w.server_index] = w.point_y;
               pos_x[w.server_index]  = w.point_x;
               pos_y[w.server_index]  = w.point_y;
               travel[w.server_index] = '0;
               r.chosen_server        = w.server_index;
            end
            OP_REQUEST: begin
               n = servers_cfg;
               if (n == 0) n = 1;
               if (n > NUM_SERVERS) n = NUM_SERVERS;
               for (int i = 1; i < n; i++)
                  if (travel[i] < travel[pick]) pick = i;
               hop          = hop_length(pos_x[pick], pos_y[pick], w.point_x, w.point_y);
               travel[pick] = sum_clip(travel[pick], SUM_BITS'(hop));
               cost_total   = sum_clip(cost_total, SUM_BITS'(hop));
               pos_x[pick]  = w.point_x;
               pos_y[pick]  = w.point_y;
               r.chosen_server = pick[IDX_BITS-1:0];
               r.step_cost     = hop;
               r.chosen_travel = travel[pick];
            end
            OP_RESTART: begin
               for (int i = 0; i < NUM_SERVERS; i++) begin
                  pos_x[i]  = home_x[i];
                  pos_y[i]  = home_y[i];
                  travel[i] = '0;
               end
               cost_total = '0;
            end
            default: ;
         endcase
         r.total_cost = cost_total;
         pending_results.push_back(r);
      endfunction

      function void report_mismatch(string what, logic [SUM_BITS-1:0] got,
                                    logic [SUM_BITS-1:0] want);
         $display("[%0t] result %0d: %s got %0d want %0d", $time, seen, what, got, want);
         mismatches++;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected word", got.total_cost, 0);
            return;
         end
         want = pending_results.pop_front();
         if (got.chosen_server !== want.chosen_server)
            report_mismatch("chosen_server", got.chosen_server, want.chosen_server);
         if (got.step_cost !== want.step_cost)
            report_mismatch("step_cost", got.step_cost, want.step_cost);
         if (got.chosen_travel !== want.chosen_travel)
            report_mismatch("chosen_travel", got.chosen_travel, want.chosen_travel);
         if (got.total_cost !== want.total_cost)
            report_mismatch("total_cost", got.total_cost, want.total_cost);
      endfunction
   endclass

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                start     = 1'b0;
   logic                busy;
   req_type             req_item  = '0;
   logic                rsp_valid;
   rsp_type             rsp_item;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CSR_BITS-1:0] csr_data  = '0;

   dispatch_tracker tracker = new();
   int              cycles  = 0;

   k_server_work_balance_dispatch_core #(.MAX_SERVERS(NUM_SERVERS)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) tracker.check_result(rsp_item);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // start stays high after a word is taken; a following word keeps it up
   task automatic send_word(req_type w);
      req_item <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      tracker.note_word(w);
   endtask

   task automatic pause(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_servers(logic [CSR_BITS-1:0] v);
      drain();
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.servers_cfg = v;
   endtask

   function automatic req_type make_word(logic [1:0] op, int idx, int x, int y);
      req_type w;
      w.opcode       = op;
      w.server_index = idx[IDX_BITS-1:0];
      w.point_x      = x[COORD_BITS-1:0];
      w.point_y      = y[COORD_BITS-1:0];
      return w;
   endfunction

   function automatic logic [COORD_BITS-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return COORD_MAX;
         default: return COORD_BITS'($urandom_range(0, COORD_MAX));
      endcase
   endfunction

   function automatic req_type random_word();
      req_type     w;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 60)      w.opcode = OP_REQUEST;
      else if (sel < 85) w.opcode = OP_PLACE;
      else if (sel < 93) w.opcode = OP_RESTART;
      else               w.opcode = OP_UNUSED;
      w.server_index = IDX_BITS'($urandom_range(0, NUM_SERVERS - 1));
      w.point_x      = pick_coord();
      w.point_y      = pick_coord();
      return w;
   endfunction

   initial begin
      logic [CSR_BITS-1:0] phase_cfg [8];
      int                  idle_pct;
      phase_cfg = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd8, 5'd3, 5'd16};
      phase_cfg[6] = CSR_BITS'($urandom_range(2, 15));
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset count of one: server 0 takes every request
      send_word(make_word(OP_REQUEST, 15, 0, 0));
      send_word(make_word(OP_REQUEST, 0, COORD_MAX, COORD_MAX));
      send_word(make_word(OP_REQUEST, 7, 0, COORD_MAX));
      send_word(make_word(OP_PLACE, 0, COORD_MAX, 0));
      send_word(make_word(OP_PLACE, 15, COORD_MAX, COORD_MAX));
      send_word(make_word(OP_UNUSED, 15, COORD_MAX, COORD_MAX));
      send_word(make_word(OP_RESTART, 10, 0, COORD_MAX));
      send_word(make_word(OP_REQUEST, 0, 0, 0));
      send_word(make_word(OP_RESTART, 0, 0, 0));
      // zero servers behaves as one
      write_servers(5'd0);
      send_word(make_word(OP_REQUEST, 3, 1, 1));
      send_word(make_word(OP_REQUEST, 3, COORD_MAX, 0));
      // above the maximum saturates to all servers
      write_servers(5'd31);
      send_word(make_word(OP_PLACE, 5, 100, 200));
      send_word(make_word(OP_REQUEST, 1, 0, 0));
      send_word(make_word(OP_REQUEST, 1, COORD_MAX, COORD_MAX));
      send_word(make_word(OP_REQUEST, 1, 2048, 2048));
      send_word(make_word(OP_RESTART, 0, 0, 0));
      send_word(make_word(OP_REQUEST, 2, 4000, 100));

      for (int p = 0; p < 8; p++) begin
         write_servers(phase_cfg[p]);
         case ($urandom_range(0, 2))
            0:       idle_pct = 0;
            1:       idle_pct = 15;
            default: idle_pct = 45;
         endcase
         if (p == 7) idle_pct = 0;
         for (int k = 0; k < 135; k++) begin
            if ($urandom_range(0, 99) < idle_pct) pause($urandom_range(1, 10));
            send_word(random_word());
         end
      end

      drain();
      if (tracker.pending_results.size() != 0)
         tracker.report_mismatch("results missing", tracker.pending_results.size(), 0);
      if (tracker.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
